/* hw/rtl/assert_macros.svh */
// assertion macros used by rtp_reorder_window.sv
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* hw/rtl/rtprw_pkg.sv */
// types and constants of the rtp reorder window
// no dependencies; used by rtprw_ctrl, rtprw_dpath and rtp_reorder_window
package rtprw_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH         = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LEAD_BYTE = 2'd2;

    localparam logic [10:0] MIN_LENGTH_RESET         = 11'd14;
    localparam logic [11:0] MAX_LENGTH_RESET         = 12'd1500;
    localparam logic [7:0]  EXPECTED_LEAD_BYTE_RESET = 8'd128;

    localparam logic [2:0] KIND_RELEASED_STORED  = 3'd0;
    localparam logic [2:0] KIND_RELEASED_CURRENT = 3'd1;
    localparam logic [2:0] KIND_INVALID_DROPPED  = 3'd2;
    localparam logic [2:0] KIND_LATE_DROPPED     = 3'd3;
    localparam logic [2:0] KIND_STORED           = 3'd4;

    typedef struct packed {
        logic [7:0]  lead_byte;
        logic [15:0] packet_length;
        logic [15:0] seq_num;
        logic [31:0] stamp;
        logic [7:0]  payload_handle;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_handle;
        logic [15:0] out_seq;
        logic        last;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load_item;
        logic emit_invalid;
        logic emit_late;
        logic commit_first;
        logic release_head;
        logic run_last;
        logic skip_head;
        logic jump;
        logic emit_current;
        logic store_item;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic invalid;
        logic late;
        logic head_valid;
        logic next_valid;
        logic any_valid;
        logic far;
        logic dist_zero;
    } t_sts;

endpackage

/* hw/rtl/rtprw_ctrl.sv */
// sequencer of the rtp reorder window: check, walk and release run
// depends on rtprw_pkg
module rtprw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rtprw_pkg::t_sts   i_sts,
    output rtprw_pkg::t_cmd   o_cmd
);
    import rtprw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.invalid || i_sts.late) begin
                    if (i_sts.out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_sts.out_free && !i_sts.head_valid && !i_sts.far) begin
                    if (i_sts.dist_zero && i_sts.next_valid) begin
                        n_state = ST_RUN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_RUN: begin
                if (i_sts.out_free && !i_sts.next_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = i_rst_n;
                o_cmd.load_item = i_in_valid && i_rst_n;
            end
            ST_CHECK: begin
                if (i_sts.invalid) begin
                    o_cmd.emit_invalid = i_sts.out_free;
                end else if (i_sts.late) begin
                    o_cmd.emit_late = i_sts.out_free;
                end else begin
                    o_cmd.commit_first = 1'b1;
                end
            end
            ST_WALK: begin
                if (i_sts.out_free) begin
                    if (i_sts.head_valid) begin
                        o_cmd.release_head = 1'b1;
                    end else if (i_sts.far) begin
                        o_cmd.skip_head = i_sts.any_valid;
                        o_cmd.jump      = !i_sts.any_valid;
                    end else if (i_sts.dist_zero) begin
                        o_cmd.emit_current = 1'b1;
                    end else begin
                        o_cmd.store_item = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (i_sts.out_free) begin
                    o_cmd.release_head = 1'b1;
                    o_cmd.run_last     = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* hw/rtl/rtprw_dpath.sv */
// datapath of the rtp reorder window: registers, ring of handles, output word
// depends on rtprw_pkg
module rtprw_dpath #(
    parameter int WINDOW      = 16,
    parameter int HANDLE_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [rtprw_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [rtprw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  rtprw_pkg::t_in_word                   i_in_word,
    input  rtprw_pkg::t_cmd                       i_cmd,
    output rtprw_pkg::t_sts                       o_sts,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output rtprw_pkg::t_out_word                  o_out_word
);
    import rtprw_pkg::*;

    localparam int HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [10:0]            r_min_len;
    logic [11:0]            r_max_len;
    logic [7:0]             r_lead_byte_ref;
    t_in_word               r_item;
    logic                   r_first_seen;
    logic [15:0]            r_exp_seq;
    logic [31:0]            r_ref_stamp;
    logic [HW-1:0]          r_head;
    logic [WINDOW-1:0]      r_valid;
    logic [HANDLE_BITS-1:0] r_handle_mem [WINDOW];
    logic [HANDLE_BITS-1:0] r_head_handle;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    logic                   n_first_seen;
    logic [15:0]            n_exp_seq;
    logic [31:0]            n_ref_stamp;
    logic [HW-1:0]          n_head;
    logic [WINDOW-1:0]      n_valid;
    logic                   n_out_valid;
    t_out_word              n_out_word;

    logic [15:0]            w_dist;
    logic [31:0]            w_stamp_diff;
    logic [HW-1:0]          w_head_inc;
    logic [HW:0]            w_slot_sum;
    logic [HW-1:0]          w_slot;
    logic [HANDLE_BITS-1:0] w_item_handle;
    logic                   w_next_valid;

    assign w_dist        = r_item.seq_num - r_exp_seq;
    assign w_stamp_diff  = r_item.stamp - r_ref_stamp;
    assign w_head_inc    = (r_head == HW'(WINDOW - 1)) ? '0 : r_head + 1'b1;
    assign w_slot_sum    = {1'b0, r_head} + {1'b0, w_dist[HW-1:0]};
    assign w_slot        = (w_slot_sum >= (HW+1)'(WINDOW)) ?
                           HW'(w_slot_sum - (HW+1)'(WINDOW)) : w_slot_sum[HW-1:0];
    assign w_item_handle = HANDLE_BITS'(r_item.payload_handle);
    assign w_next_valid  = r_valid[w_head_inc];

    always_comb begin
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.invalid    = (r_item.packet_length < {5'd0, r_min_len})
                        || (r_item.packet_length >= {4'd0, r_max_len})
                        || (r_item.lead_byte != r_lead_byte_ref);
        o_sts.late       = !r_first_seen && (w_dist[15] || w_stamp_diff[31]);
        o_sts.head_valid = r_valid[r_head];
        o_sts.next_valid = w_next_valid;
        o_sts.any_valid  = |r_valid;
        o_sts.far        = w_dist >= 16'(WINDOW);
        o_sts.dist_zero  = w_dist == '0;
    end

    always_comb begin
        n_first_seen = r_first_seen;
        n_exp_seq    = r_exp_seq;
        n_ref_stamp  = r_ref_stamp;
        n_head       = r_head;
        n_valid      = r_valid;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_word   = r_out_word;

        if (i_cmd.commit_first && r_first_seen) begin
            n_first_seen = 1'b0;
            n_exp_seq    = r_item.seq_num;
            n_ref_stamp  = r_item.stamp;
        end

        if (i_cmd.release_head || i_cmd.skip_head || i_cmd.emit_current) begin
            n_exp_seq = r_exp_seq + 16'd1;
            n_head    = w_head_inc;
        end

        // empty ring: jump straight to the last in-window position
        if (i_cmd.jump) begin
            n_exp_seq = r_item.seq_num - 16'(WINDOW - 1);
        end

        if (i_cmd.release_head) begin
            n_valid[r_head] = 1'b0;
        end

        if (i_cmd.store_item) begin
            n_valid[w_slot] = 1'b1;
        end

        if (i_cmd.emit_invalid || i_cmd.emit_late || i_cmd.emit_current
                || i_cmd.store_item) begin
            n_out_valid           = 1'b1;
            n_out_word.out_handle = 8'(w_item_handle);
            n_out_word.out_seq    = r_item.seq_num;
            n_out_word.last       = 1'b1;
            if (i_cmd.emit_invalid) begin
                n_out_word.kind = KIND_INVALID_DROPPED;
            end else if (i_cmd.emit_late) begin
                n_out_word.kind = KIND_LATE_DROPPED;
            end else if (i_cmd.emit_current) begin
                n_out_word.kind = KIND_RELEASED_CURRENT;
                n_out_word.last = !w_next_valid;
            end else begin
                n_out_word.kind = KIND_STORED;
            end
        end else if (i_cmd.release_head) begin
            n_out_valid           = 1'b1;
            n_out_word.kind       = KIND_RELEASED_STORED;
            n_out_word.out_handle = 8'(r_head_handle);
            n_out_word.out_seq    = r_exp_seq;
            n_out_word.last       = i_cmd.run_last && !w_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len       <= MIN_LENGTH_RESET;
            r_max_len       <= MAX_LENGTH_RESET;
            r_lead_byte_ref <= EXPECTED_LEAD_BYTE_RESET;
            r_first_seen    <= 1'b1;
            r_exp_seq       <= '0;
            r_ref_stamp     <= '0;
            r_head          <= '0;
            r_valid         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_LENGTH:         r_min_len       <= i_cfg_data[10:0];
                    CFG_MAX_LENGTH:         r_max_len       <= i_cfg_data[11:0];
                    CFG_EXPECTED_LEAD_BYTE: r_lead_byte_ref <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_first_seen <= n_first_seen;
            r_exp_seq    <= n_exp_seq;
            r_ref_stamp  <= n_ref_stamp;
            r_head       <= n_head;
            r_valid      <= n_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_word;
        end
        r_out_word <= n_out_word;
    end

    // handle ring, read ahead at the next head position
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_item) begin
            r_handle_mem[w_slot] <= w_item_handle;
        end
        r_head_handle <= r_handle_mem[n_head];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* hw/rtl/rtp_reorder_window.sv */
// channel   dir   handshake                  word
// input     in    i_in_valid / o_in_ready    i_in_word (t_in_word)
// output    out   o_out_valid / i_out_ready  o_out_word (t_out_word)
// config    in    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a word is taken in idle, checked in the next cycle, then the ring is walked one slot per cycle
// while the output register has room; a drop is emitted in the check state, while a store or
// in-order word is walked to its slot; a far word with an empty ring moves the expected number in a single jump
// results come through one output register; a step that emits waits while it is full and not being read
// synchronous reset empties the ring and restores the register defaults
// top level of the rtp reorder window; depends on rtprw_pkg, rtprw_ctrl, rtprw_dpath
`include "assert_macros.svh"
module rtp_reorder_window #(
    parameter int WINDOW      = 16,
    parameter int HANDLE_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rtprw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rtprw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rtprw_pkg::t_in_word               i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rtprw_pkg::t_out_word              o_out_word
);
    import rtprw_pkg::*;

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic       w_emit;
    logic [2:0] w_step;

    assign o_cfg_ready = i_rst_n;

    rtprw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rtprw_dpath #(
        .WINDOW      (WINDOW),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    assign w_emit = w_cmd.emit_invalid || w_cmd.emit_late || w_cmd.release_head
                 || w_cmd.emit_current || w_cmd.store_item;
    assign w_step = {w_emit, w_cmd.skip_head, w_cmd.jump};

    `ASSERT_HOLDS(a_emit_needs_room, i_clk, i_rst_n, w_emit |-> w_sts.out_free, "emit when full")
    `ASSERT_HOLDS(a_one_word, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "busy")
    `ASSERT_NEVER(a_head_empty, i_clk, i_rst_n, o_in_ready && w_sts.head_valid, "head occupied")
    `ASSERT_HOLDS(a_single_step, i_clk, i_rst_n, $onehot0(w_step), "more than one ring step")

endmodule

/* dv/tb.sv */
// testbench of rtp_reorder_window: directed table, then random phases over several register sets
// depends on rtprw_pkg and rtp_reorder_window; results are checked against a reorder predictor
`timescale 1ns / 1ps

module tb;
    import rtprw_pkg::*;

    localparam int RW_WINDOW       = 16;
    localparam logic [7:0] HANDLE_MASK = 8'((1 << 8) - 1);
    localparam int ITEMS_PER_PHASE = 50;
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 40;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_in_word               i_in_word = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_word              o_out_word;

    rtp_reorder_window #(
        .WINDOW(RW_WINDOW),
        .HANDLE_BITS(8)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word(o_out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // register copies
    logic [10:0] cfg_min = MIN_LENGTH_RESET;
    logic [11:0] cfg_max = MAX_LENGTH_RESET;
    logic [7:0]  cfg_fb  = EXPECTED_LEAD_BYTE_RESET;

    // reorder ring copy
    logic        rw_awaiting_first = 1'b1;
    logic [15:0] rw_next_seq = '0;
    logic [31:0] rw_ref_stamp = '0;
    logic [3:0]  rw_head = '0;
    logic        rw_full [RW_WINDOW];
    logic [7:0]  rw_handle [RW_WINDOW];

    t_out_word step_words[$];
    t_out_word pending_words[$];
    t_out_word head_word;
    int        errors = 0;

    int idle_mode = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    typedef struct {
        t_in_word   w;
        bit         typed;
        logic [2:0] kind;
    } t_dir_row;

    t_dir_row dir_rows[$];

    function automatic t_out_word mk_out(logic [2:0] kind, logic [7:0] h, logic [15:0] s);
        t_out_word r;
        r.kind = kind;
        r.out_handle = h & HANDLE_MASK;
        r.out_seq = s;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void advance_head();
        rw_next_seq = rw_next_seq + 16'd1;
        rw_head = rw_head + 4'd1;
    endfunction

    function automatic void release_stored();
        while (rw_full[rw_head] && step_words.size() < RW_WINDOW) begin
            step_words.push_back(mk_out(KIND_RELEASED_STORED, rw_handle[rw_head], rw_next_seq));
            rw_full[rw_head] = 1'b0;
            advance_head();
        end
    endfunction

    function automatic void predict_reorder(input t_in_word w, input bit keep);
        logic [15:0] gap;
        logic [31:0] sdiff;
        logic [7:0]  h;
        logic [3:0]  slot;
        t_out_word   tail;
        step_words.delete();
        h = w.payload_handle & HANDLE_MASK;
        if (w.packet_length < {5'd0, cfg_min} || w.packet_length >= {4'd0, cfg_max}
                || w.lead_byte != cfg_fb) begin
            step_words.push_back(mk_out(KIND_INVALID_DROPPED, h, w.seq_num));
        end else begin
            if (rw_awaiting_first) begin
                rw_next_seq = w.seq_num;
                rw_ref_stamp = w.stamp;
                rw_awaiting_first = 1'b0;
            end
            gap = w.seq_num - rw_next_seq;
            sdiff = w.stamp - rw_ref_stamp;
            if (gap[15] || sdiff[31]) begin
                step_words.push_back(mk_out(KIND_LATE_DROPPED, h, w.seq_num));
            end else begin
                while (gap >= RW_WINDOW) begin
                    if (!rw_full[rw_head]) advance_head();
                    release_stored();
                    gap = w.seq_num - rw_next_seq;
                end
                if (gap == 16'd0) begin
                    step_words.push_back(mk_out(KIND_RELEASED_CURRENT, h, w.seq_num));
                    advance_head();
                    release_stored();
                end else begin
                    slot = rw_head + gap[3:0];
                    rw_full[slot] = 1'b1;
                    rw_handle[slot] = h;
                    step_words.push_back(mk_out(KIND_STORED, h, w.seq_num));
                end
            end
        end
        tail = step_words.pop_back();
        tail.last = 1'b1;
        step_words.push_back(tail);
        if (keep) begin
            foreach (step_words[i]) pending_words.push_back(step_words[i]);
        end
    endfunction

    function automatic void add_dir(logic [7:0] fb, logic [15:0] len, logic [15:0] s,
                                    logic [31:0] st, logic [7:0] h, bit typed,
                                    logic [2:0] kind);
        t_dir_row r;
        r.w.lead_byte = fb;
        r.w.packet_length = len;
        r.w.seq_num = s;
        r.w.stamp = st;
        r.w.payload_handle = h;
        r.typed = typed;
        r.kind = kind;
        dir_rows.push_back(r);
    endfunction

    function automatic t_in_word good_word(logic [15:0] s);
        t_in_word w;
        w.lead_byte = cfg_fb;
        w.packet_length = 16'($urandom_range(int'(cfg_max) - 1, int'(cfg_min)));
        if ($urandom_range(3) == 0) w.stamp = rw_ref_stamp + $urandom_range(0, 64);
        else w.stamp = rw_ref_stamp + ($urandom & 32'h7FFF_FFFF);
        w.seq_num = s;
        w.payload_handle = 8'($urandom);
        return w;
    endfunction

    task automatic send_word(input t_in_word w, input bit typed, input logic [2:0] kind);
        int pct;
        t_out_word t;
        pct = (idle_mode == 1) ? 49 : 23;
        i_in_word <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_reorder(w, !typed);
        if (typed) begin
            t = mk_out(kind, w.payload_handle, w.seq_num);
            t.last = 1'b1;
            pending_words.push_back(t);
        end
        while ((idle_mode == 1 || idle_mode == 3) && $urandom_range(99) < pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [11:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MIN_LENGTH: cfg_min = val[10:0];
            CFG_MAX_LENGTH: cfg_max = val;
            CFG_EXPECTED_LEAD_BYTE: cfg_fb = val[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_mode >= 2) begin
            i_out_ready <= ($urandom_range(99) >= ((idle_mode == 2) ? 49 : 23));
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, actual kind %0d handle %h seq %h last %b",
                         $time, o_out_word.kind, o_out_word.out_handle, o_out_word.out_seq,
                         o_out_word.last);
                errors++;
            end else begin
                head_word = pending_words.pop_front();
                if (o_out_word.kind !== head_word.kind
                        || o_out_word.out_handle !== head_word.out_handle
                        || o_out_word.out_seq !== head_word.out_seq
                        || o_out_word.last !== head_word.last) begin
                    $display("%0t: mismatch, expected kind %0d handle %h seq %h last %b, %s",
                             $time, head_word.kind, head_word.out_handle, head_word.out_seq,
                             head_word.last, "see actual below");
                    $display("%0t: actual kind %0d handle %h seq %h last %b", $time,
                             o_out_word.kind, o_out_word.out_handle, o_out_word.out_seq,
                             o_out_word.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    logic [10:0] min_tab [NUM_PHASES] = '{11'd14, 11'd0, 11'd2047, 11'd0,
                                         11'd20, 11'd100, 11'd0, 11'd0};
    logic [11:0] max_tab [NUM_PHASES] = '{12'd1500, 12'd2048, 12'd2048, 12'd1,
                                         12'd600, 12'd2048, 12'd64, 12'd0};
    logic [7:0]  fb_tab [NUM_PHASES]  = '{8'd128, 8'd0, 8'd255, 8'd128,
                                         8'h80, 8'h5A, 8'hFF, 8'd0};

    initial begin
        int sent;
        int choice;
        int blen;
        int j;
        int tmp;
        int offs [RW_WINDOW];
        logic [15:0] base;
        t_in_word w;

        foreach (rw_full[i]) rw_full[i] = 1'b0;
        foreach (rw_handle[i]) rw_handle[i] = '0;
        min_tab[7] = 11'($urandom_range(200, 0));
        max_tab[7] = 12'($urandom_range(2048, int'(min_tab[7]) + 1));
        fb_tab[7] = 8'($urandom);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_dir(8'h00, 16'd100, 16'd5, 32'd0, 8'h00, 1, KIND_INVALID_DROPPED);
        add_dir(8'hFF, 16'd100, 16'd6, 32'hFFFF_FFFF, 8'hFF, 1, KIND_INVALID_DROPPED);
        add_dir(8'd128, 16'd13, 16'd7, 32'd0, 8'h11, 1, KIND_INVALID_DROPPED);
        add_dir(8'd128, 16'd1500, 16'd8, 32'd0, 8'h22, 1, KIND_INVALID_DROPPED);
        add_dir(8'd128, 16'hFFFF, 16'hFFFF, 32'd0, 8'h33, 1, KIND_INVALID_DROPPED);
        add_dir(8'd128, 16'd14, 16'd100, 32'd1000, 8'hAA, 1, KIND_RELEASED_CURRENT);
        add_dir(8'd128, 16'd1499, 16'd99, 32'd1000, 8'h01, 1, KIND_LATE_DROPPED);
        add_dir(8'd128, 16'd200, 16'd101, 32'd999, 8'h02, 1, KIND_LATE_DROPPED);
        add_dir(8'd128, 16'd200, 16'd101, 32'hFFFF_FFFF, 8'h02, 1, KIND_LATE_DROPPED);
        add_dir(8'd128, 16'd200, 16'd103, 32'd2000, 8'h03, 1, KIND_STORED);
        add_dir(8'd128, 16'd200, 16'd103, 32'd2000, 8'h04, 1, KIND_STORED);
        add_dir(8'd128, 16'd200, 16'd102, 32'd2000, 8'h05, 0, KIND_RELEASED_CURRENT);
        add_dir(8'd128, 16'd300, 16'd119, 32'h8000_03E7, 8'h00, 0, KIND_STORED);
        add_dir(8'd128, 16'd300, 16'd120, 32'd5000, 8'hFF, 0, KIND_STORED);
        add_dir(8'd128, 16'd300, 16'hFFFF, 32'd5000, 8'h44, 0, KIND_LATE_DROPPED);
        add_dir(8'd128, 16'd300, 16'h8068, 32'd5000, 8'h55, 0, KIND_STORED);
        add_dir(8'd128, 16'd300, 16'h8059, 32'd5000, 8'h66, 0, KIND_RELEASED_CURRENT);

        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].kind);
        wait_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_MIN_LENGTH, {1'b0, min_tab[p]});
            write_reg(CFG_MAX_LENGTH, max_tab[p]);
            write_reg(CFG_EXPECTED_LEAD_BYTE, {4'd0, fb_tab[p]});
            idle_mode = p % 4;
            if (p == 0) hold_token = hold_token + 1;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (p == 2 && sent >= ITEMS_PER_PHASE / 2 && sent < ITEMS_PER_PHASE / 2 + 4)
                    wait_results();
                choice = $urandom_range(99);
                if (choice < 70) begin
                    blen = ($urandom_range(7) == 0) ? RW_WINDOW : $urandom_range(8, 1);
                    base = rw_next_seq;
                    for (int i = 0; i < RW_WINDOW; i++) offs[i] = i;
                    for (int i = blen - 1; i > 0; i--) begin
                        j = $urandom_range(i, 0);
                        tmp = offs[i];
                        offs[i] = offs[j];
                        offs[j] = tmp;
                    end
                    if (blen == RW_WINDOW) begin
                        for (int i = 0; i < RW_WINDOW; i++) begin
                            if (offs[i] == 0) begin
                                offs[i] = offs[RW_WINDOW - 1];
                                offs[RW_WINDOW - 1] = 0;
                            end
                        end
                    end
                    for (int i = 0; i < blen; i++) begin
                        w = good_word(base + 16'(offs[i]));
                        send_word(w, 0, KIND_STORED);
                        sent++;
                        if ($urandom_range(19) == 0) begin
                            w.payload_handle = 8'($urandom);
                            send_word(w, 0, KIND_STORED);
                            sent++;
                        end
                    end
                end else if (choice < 80) begin
                    if ($urandom_range(4) == 0)
                        w = good_word(rw_next_seq + 16'($urandom_range(16'h7FFF, 16)));
                    else
                        w = good_word(rw_next_seq + 16'($urandom_range(40, 16)));
                    send_word(w, 0, KIND_STORED);
                    sent++;
                end else if (choice < 88) begin
                    if ($urandom_range(1) == 0) begin
                        w = good_word(rw_next_seq - 16'($urandom_range(16'h8000, 1)));
                    end else begin
                        w = good_word(rw_next_seq + 16'($urandom_range(15, 0)));
                        w.stamp = rw_ref_stamp + 32'h8000_0000 + ($urandom & 32'h7FFF_FFFF);
                    end
                    send_word(w, 0, KIND_LATE_DROPPED);
                    sent++;
                end else begin
                    w.lead_byte = 8'($urandom);
                    w.packet_length = 16'($urandom);
                    w.seq_num = 16'($urandom);
                    w.stamp = $urandom;
                    w.payload_handle = 8'($urandom);
                    if ($urandom_range(1) == 0) w.lead_byte = cfg_fb;
                    send_word(w, 0, KIND_INVALID_DROPPED);
                    sent++;
                end
            end
            wait_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, pending_words.size());
            errors++;
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rtprw_pkg.sv
hw/rtl/rtprw_ctrl.sv
hw/rtl/rtprw_dpath.sv
hw/rtl/rtp_reorder_window.sv
dv/tb.sv
